/* design/aggregation_walker_step_macros.svh */
// ----------------------------------------------------------------------------
// aggregation walker step assertion macros
// concurrent assertion shorthands, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef AGGREGATION_WALKER_STEP_MACROS_SVH
`define AGGREGATION_WALKER_STEP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aggregation walker step: assertion failed");
// next-cycle implication
`define AWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aggregation walker step: assertion failed");
`else
`define AWS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/aws_pkg.sv */
// ----------------------------------------------------------------------------
// aws_pkg
// shared types, codes and helpers of the aggregation walker step block
// ----------------------------------------------------------------------------
`default_nettype none

package aws_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int POS_W          = 8;
  localparam int SIZE_W         = 9;
  localparam int POS_LIMIT      = 256;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SEED  = 2'd1,
    OP_WALK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic {
    REG_BOARD_WIDTH  = 1'b0,
    REG_BOARD_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROW_C   = 2'd0,
    ROW_UP  = 2'd1,
    ROW_DN  = 2'd2,
    ROW_CNT = 2'd3
  } row_sel_t;

  typedef struct packed {
    logic     load;
    logic     test;
    logic     rd_en;
    row_sel_t rd_sel;
    logic     wr_en;
    row_sel_t wr_sel;
    logic     cnt_inc;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic centre;
    logic cnt_last;
  } sts_t;

  // saturate a size register into 3..lim
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r > lim) r = lim;
    if (r < SIZE_W'(3)) r = SIZE_W'(3);
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/aws_ctrl.sv */
// ----------------------------------------------------------------------------
// aws_ctrl
// sequencer: request intake, row read/modify/write steps, clear sweeps, result
// ----------------------------------------------------------------------------
`default_nettype none

module aws_ctrl
  import aws_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire  [1:0] in_op,
  output logic       in_stall,
  output logic       out_valid,
  input  wire        out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_CLR  = 8'b0000_0100,
    S_RDC  = 8'b0000_1000,
    S_TEST = 8'b0001_0000,
    S_UP   = 8'b0010_0000,
    S_DN   = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   mark;

  // seed marks a free centre, walk marks around a sticky one
  assign mark = (sts.op == OP_SEED && !sts.centre) || (sts.op == OP_WALK && sts.centre);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.rd_sel    = ROW_C;
    cmd.wr_sel    = ROW_C;
    unique case (state_r)
      S_INIT, S_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ROW_CNT;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (op_t'(in_op))
            OP_CLEAR:        state_nxt = S_CLR;
            OP_SEED, OP_WALK: state_nxt = S_RDC;
            OP_NONE:         state_nxt = S_DONE;
          endcase
        end
      end
      S_RDC: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ROW_C;
        state_nxt  = S_TEST;
      end
      S_TEST: begin
        cmd.test = 1'b1;
        if (mark) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ROW_C;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ROW_UP;
          state_nxt  = S_UP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_UP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ROW_UP;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ROW_DN;
        state_nxt  = S_DN;
      end
      S_DN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ROW_DN;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* design/aws_dp.sv */
// ----------------------------------------------------------------------------
// aws_dp
// datapath: size registers, row-wide sticky bitmap, neighbour mask, result
// ----------------------------------------------------------------------------
`default_nettype none

module aws_dp
  import aws_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire  [SIZE_W-1:0] cfg_wdata,
  input  wire  [1:0]        in_op,
  input  wire  [POS_W-1:0]  in_pos_x,
  input  wire  [POS_W-1:0]  in_pos_y,
  input  wire  [1:0]        in_direction,
  output logic              out_hit,
  output logic [POS_W-1:0]  out_new_x,
  output logic [POS_W-1:0]  out_new_y,
  input  cmd_t              cmd,
  output sts_t              sts
);

  localparam int MEM_W  = (MAX_WIDTH < POS_LIMIT) ? MAX_WIDTH : POS_LIMIT;
  localparam int MEM_H  = (MAX_HEIGHT < POS_LIMIT) ? MAX_HEIGHT : POS_LIMIT;
  localparam int COL_AW = $clog2(MEM_W);
  localparam int ROW_AW = $clog2(MEM_H);
  localparam logic [SIZE_W-1:0] LIM_W = SIZE_W'(MEM_W);
  localparam logic [SIZE_W-1:0] LIM_H = SIZE_W'(MEM_H);

  // row-organized bitmap, one row per word
  logic [MEM_W-1:0] mem [MEM_H];
  logic [MEM_W-1:0] rdata_r;

  logic [SIZE_W-1:0] w_eff_r, h_eff_r;
  op_t               op_r;
  dir_t              dir_r;
  logic [POS_W-1:0]  x_r, y_r, y_up, y_dn;
  logic              hit_r;
  logic [POS_W-1:0]  res_x_r, res_y_r, step_x, step_y;
  logic [ROW_AW-1:0] cnt_r, cnt_nxt;
  logic [ROW_AW-1:0] raddr, waddr;
  logic [MEM_W-1:0]  mask, wdata;
  logic              we, row_ok;
  logic              vc, vu, vd, centre;

  // effective sizes kept already saturated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= LIM_W;
      h_eff_r <= LIM_H;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BOARD_WIDTH:  w_eff_r <= clamp_size(cfg_wdata, LIM_W);
        REG_BOARD_HEIGHT: h_eff_r <= clamp_size(cfg_wdata, LIM_H);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_op);
      dir_r <= dir_t'(in_direction);
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
    end
  end

  assign y_up = y_r - POS_W'(1);
  assign y_dn = y_r + POS_W'(1);

  // rows that lie on the board
  assign vc = {1'b0, y_r} < h_eff_r;
  assign vu = (y_r != '0) && ({1'b0, y_r} <= h_eff_r);
  assign vd = ({1'b0, y_r} + SIZE_W'(1)) < h_eff_r;

  assign centre = vc && ({1'b0, x_r} < w_eff_r) && rdata_r[x_r[COL_AW-1:0]];

  // columns x-1..x+1 clipped to the board
  always_comb begin
    logic [SIZE_W-1:0] col;
    for (int i = 0; i < MEM_W; i++) begin
      col     = SIZE_W'(i);
      mask[i] = (col < w_eff_r) && ({1'b0, x_r} <= col + SIZE_W'(1))
                && (col <= {1'b0, x_r} + SIZE_W'(1));
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      ROW_UP:  raddr = y_up[ROW_AW-1:0];
      ROW_DN:  raddr = y_dn[ROW_AW-1:0];
      ROW_C:   raddr = y_r[ROW_AW-1:0];
      ROW_CNT: raddr = cnt_r;
    endcase
  end

  always_comb begin
    wdata = rdata_r | mask;
    unique case (cmd.wr_sel)
      ROW_UP: begin
        waddr  = y_up[ROW_AW-1:0];
        row_ok = vu;
      end
      ROW_DN: begin
        waddr  = y_dn[ROW_AW-1:0];
        row_ok = vd;
      end
      ROW_C: begin
        waddr  = y_r[ROW_AW-1:0];
        row_ok = vc;
      end
      ROW_CNT: begin
        waddr  = cnt_r;
        row_ok = 1'b1;
        wdata  = '0;
      end
    endcase
  end

  assign we = cmd.wr_en && row_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // sweep counter for clearing passes
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = (cnt_r == ROW_AW'(MEM_H - 1)) ? '0 : cnt_r + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // walker move, blocked at the interior wall it would cross
  always_comb begin
    step_x = x_r;
    step_y = y_r;
    unique case (dir_r)
      DIR_LEFT:  if (x_r > POS_W'(1)) step_x = x_r - POS_W'(1);
      DIR_RIGHT: if ({1'b0, x_r} < w_eff_r - SIZE_W'(2)) step_x = x_r + POS_W'(1);
      DIR_UP:    if (y_r > POS_W'(1)) step_y = y_r - POS_W'(1);
      DIR_DOWN:  if ({1'b0, y_r} < h_eff_r - SIZE_W'(2)) step_y = y_r + POS_W'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r <= 1'b0;
      if (op_t'(in_op) == OP_SEED || op_t'(in_op) == OP_WALK) begin
        res_x_r <= in_pos_x;
        res_y_r <= in_pos_y;
      end else begin
        res_x_r <= '0;
        res_y_r <= '0;
      end
    end else if (cmd.test) begin
      hit_r <= centre;
      if (op_r == OP_WALK && !centre) begin
        res_x_r <= step_x;
        res_y_r <= step_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit   <= hit_r;
      out_new_x <= res_x_r;
      out_new_y <= res_y_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.centre   = centre;
  assign sts.cnt_last = (cnt_r == ROW_AW'(MEM_H - 1));

endmodule

`default_nettype wire

/* design/aggregation_walker_step.sv */
// ----------------------------------------------------------------------------
// aggregation_walker_step
// sticky-cell bitmap engine for seeding, walking and sticking on a board
// ----------------------------------------------------------------------------
// usage:
//   in_* carries one request (op, pos_x, pos_y, direction), taken when
//   in_valid is high and in_stall low. out_* returns exactly one result
//   (hit, new_x, new_y) per request, taken when out_valid is high and
//   out_stall low. cfg_* writes board_width (index 0) or board_height
//   (index 1); cfg_ready is always high, writes belong in idle periods.
//   one request is worked at a time; intake reopens once its result has
//   been loaded into the output register. the steps of each request are:
//     seed or walk that marks nothing: row read, test, result
//     seed or walk that marks a 3x3 block: three row read/modify/writes, result
//     clear: rows = min(MAX_HEIGHT, 256), one row zeroed a cycle, then result
//     op code three: result only
//   the row memory (one read and one write port) and its read/modify/write
//   sequence set these steps. after reset the bitmap is zeroed by a sweep
//   of min(MAX_HEIGHT, 256) rows with in_stall high; config writes are taken.
//   a finished result sits in the output register while the next request
//   is accepted; a stalled receiver only holds back the following result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aggregation_walker_step_macros.svh"

module aggregation_walker_step
  import aws_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire               clk,
  input  wire               rst_n,
  // request channel
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [1:0]        in_op,
  input  wire  [POS_W-1:0]  in_pos_x,
  input  wire  [POS_W-1:0]  in_pos_y,
  input  wire  [1:0]        in_direction,
  // result channel
  output logic              out_valid,
  input  wire               out_stall,
  output logic              out_hit,
  output logic [POS_W-1:0]  out_new_x,
  output logic [POS_W-1:0]  out_new_y,
  // configuration write channel
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_index,
  input  wire  [SIZE_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // size registers can always take a write
  assign cfg_ready = 1'b1;

  // sequencer: owns handshakes and the step order
  aws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bitmap memory, mask generation, walker move and result registers
  aws_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_op        (in_op),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_direction (in_direction),
    .out_hit      (out_hit),
    .out_new_x    (out_new_x),
    .out_new_y    (out_new_y),
    .cmd          (cmd),
    .sts          (sts)
  );

  // a taken request closes the intake in the following cycle
  `AWS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)
  // a result only appears at the end of work on a request
  `AWS_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))
  // the bitmap is never written while the intake is open
  `AWS_ASSERT_NOW(a_no_write_idle, clk, rst_n, cmd.wr_en, in_stall)

endmodule

`default_nettype wire
